// ===== rtl/core/ethernet_ipv4_header_parser_core_assert.svh =====
// Assertion macros for the Ethernet/IPv4 header parser core.
`ifndef ETHERNET_IPV4_HEADER_PARSER_CORE_ASSERT_SVH
`define ETHERNET_IPV4_HEADER_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define EIHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define EIHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/eihp_pkg.sv =====
// Package: status codes and header constants for the Ethernet/IPv4 parser.
package eihp_pkg;

  typedef enum logic [2:0] {
    ST_ICMP      = 3'd0,
    ST_TCP       = 3'd1,
    ST_UDP       = 3'd2,
    ST_NOT_IPV4  = 3'd3,
    ST_SHORT_HDR = 3'd4,
    ST_OTHER     = 3'd5,
    ST_TRUNC     = 3'd6
  } status_t;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [6:0]  ETH_HDR_LEN    = 7'd14;
  localparam logic [6:0]  IHL_OFFSET     = 7'd14;
  localparam logic [6:0]  PROTO_OFFSET   = 7'd23;
  localparam logic [6:0]  SIP_OFFSET     = 7'd26;
  localparam logic [6:0]  DIP_OFFSET     = 7'd30;
  localparam logic [5:0]  MIN_IP_HDR     = 6'd20;
  localparam logic [6:0]  OFFSET_MAX     = 7'd127;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  ICMP_NEED      = 8'd2;
  localparam logic [7:0]  UDP_NEED       = 8'd4;
  localparam logic [7:0]  TCP_NEED       = 8'd12;

endpackage

// ===== rtl/core/ethernet_ipv4_header_parser_core.sv =====
// Top level: Ethernet/IPv4/L4 header parser, one frame byte per item.
//
// Takes a frame one byte per item (in_data_byte, with in_end_of_frame on the
// last byte) and emits one result item per frame, on its last byte. Bytes go
// into an input register, then one pass of short logic captures the byte at
// its frame offset (MACs, ethertype, IHL, protocol, IP addresses, and the
// transport bytes at offset 14 + IHL*4) and, on the last byte, forms the
// status and gated fields straight into the result register. A new byte is
// taken every clock while in_stall is low; out_valid rises as the result of a
// frame's last byte is registered. in_stall rises only when a last byte waits
// in the input register while the previous result is still held by out_stall,
// so a stalled sink costs only the cycles in which it holds the result. All
// state clears after each last byte. Status: 0 icmp, 1 tcp, 2 udp, 3 not IPv4,
// 4 IP header under 20 bytes, 5 other protocol, 6 truncated. The offset counter
// saturates at 127; bytes past every captured position are ignored.
module ethernet_ipv4_header_parser_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_end_of_frame,
  output logic             out_valid,
  input  logic             out_stall,
  output eihp_pkg::status_t out_status,
  output logic [47:0]      out_dest_mac,
  output logic [47:0]      out_source_mac,
  output logic [31:0]      out_source_ip,
  output logic [31:0]      out_dest_ip,
  output logic [15:0]      out_source_port,
  output logic [15:0]      out_dest_port,
  output logic [31:0]      out_seq_number,
  output logic [31:0]      out_ack_number,
  output logic [7:0]       out_icmp_kind,
  output logic [7:0]       out_icmp_subcode
);
  import eihp_pkg::*;

  // input stage
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_eof_r;

  // per-frame capture state
  logic [6:0]  off_r;
  logic [15:0] etype_r,  etype_nxt;
  logic [5:0]  ihb_r,    ihb_nxt;
  logic [7:0]  proto_r,  proto_nxt;
  logic [47:0] dmac_r,   dmac_nxt;
  logic [47:0] smac_r,   smac_nxt;
  logic [31:0] sip_r,    sip_nxt;
  logic [31:0] dip_r,    dip_nxt;
  logic [31:0] ports_r,  ports_nxt;
  logic [31:0] seq_r,    seq_nxt;
  logic [31:0] ack_r,    ack_nxt;
  logic [15:0] icmp_r,   icmp_nxt;

  // result register
  logic    out_vld_r;
  status_t st_r;
  logic [47:0] o_dmac_r, o_smac_r;
  logic [31:0] o_sip_r, o_dip_r, o_seq_r, o_ack_r;
  logic [15:0] o_sport_r, o_dport_r;
  logic [7:0]  o_ikind_r, o_icode_r;

  logic    blocked;
  logic    s1_go;
  logic    in_take;
  logic [6:0] base;
  logic [3:0] t;
  logic       xport_en;
  logic [7:0] cnt;
  logic [7:0] need;
  status_t    st_nxt;

  // Only a last byte can be held up, and only by a result nobody took yet.
  assign blocked  = in_eof_r && out_vld_r && out_stall;
  assign s1_go    = in_vld_r && !blocked;
  assign in_stall = in_vld_r && blocked;
  assign in_take  = in_valid && !in_stall;

  // Transport window: [14 + IHL*4, 14 + IHL*4 + 12), once IHL is known and sane.
  // Inside the window the offset fits in four bits.
  assign base   = ETH_HDR_LEN + {1'b0, ihb_r};
  assign t      = off_r[3:0] - base[3:0];
  assign xport_en = (off_r > IHL_OFFSET) && (ihb_r >= MIN_IP_HDR) && (off_r >= base) &&
                    ({1'b0, off_r} < ({1'b0, base} + TCP_NEED));

  always_comb begin
    dmac_nxt  = dmac_r;
    smac_nxt  = smac_r;
    etype_nxt = etype_r;
    ihb_nxt   = ihb_r;
    proto_nxt = proto_r;
    sip_nxt   = sip_r;
    dip_nxt   = dip_r;
    ports_nxt = ports_r;
    seq_nxt   = seq_r;
    ack_nxt   = ack_r;
    icmp_nxt  = icmp_r;
    // byte lanes, first byte most significant
    for (int i = 0; i < 6; i++) begin
      if (off_r == 7'(i))      dmac_nxt[47-8*i -: 8] = in_byte_r;
      if (off_r == 7'(i + 6))  smac_nxt[47-8*i -: 8] = in_byte_r;
    end
    for (int i = 0; i < 2; i++) begin
      if (off_r == 7'(i + 12)) etype_nxt[15-8*i -: 8] = in_byte_r;
    end
    if (off_r == IHL_OFFSET)   ihb_nxt   = {in_byte_r[3:0], 2'b00};
    if (off_r == PROTO_OFFSET) proto_nxt = in_byte_r;
    for (int i = 0; i < 4; i++) begin
      if (off_r == SIP_OFFSET + 7'(i)) sip_nxt[31-8*i -: 8] = in_byte_r;
      if (off_r == DIP_OFFSET + 7'(i)) dip_nxt[31-8*i -: 8] = in_byte_r;
    end
    if (xport_en) begin
      for (int i = 0; i < 4; i++) begin
        if (t == 4'(i))     ports_nxt[31-8*i -: 8] = in_byte_r;
        if (t == 4'(i + 4)) seq_nxt[31-8*i -: 8]   = in_byte_r;
        if (t == 4'(i + 8)) ack_nxt[31-8*i -: 8]   = in_byte_r;
      end
      for (int i = 0; i < 2; i++) begin
        if (t == 4'(i)) icmp_nxt[15-8*i -: 8] = in_byte_r;
      end
    end
  end

  // Status from the state as it stands with this byte included.
  assign cnt  = {1'b0, off_r} + 8'd1;
  assign need = {2'b00, ihb_nxt} + {1'b0, ETH_HDR_LEN};

  always_comb begin
    priority if (cnt < {1'b0, ETH_HDR_LEN})          st_nxt = ST_TRUNC;
    else if (etype_nxt != ETHERTYPE_IPV4)            st_nxt = ST_NOT_IPV4;
    else if (cnt < {1'b0, IHL_OFFSET} + 8'd1)        st_nxt = ST_TRUNC;
    else if (ihb_nxt < MIN_IP_HDR)                   st_nxt = ST_SHORT_HDR;
    else if (cnt < {1'b0, PROTO_OFFSET} + 8'd1)      st_nxt = ST_TRUNC;
    else if (proto_nxt == PROTO_ICMP)
      st_nxt = (cnt < need + ICMP_NEED) ? ST_TRUNC : ST_ICMP;
    else if (proto_nxt == PROTO_TCP)
      st_nxt = (cnt < need + TCP_NEED) ? ST_TRUNC : ST_TCP;
    else if (proto_nxt == PROTO_UDP)
      st_nxt = (cnt < need + UDP_NEED) ? ST_TRUNC : ST_UDP;
    else                                             st_nxt = ST_OTHER;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      off_r     <= '0;
      etype_r   <= '0;
      ihb_r     <= '0;
      proto_r   <= '0;
      dmac_r    <= '0;
      smac_r    <= '0;
      sip_r     <= '0;
      dip_r     <= '0;
      ports_r   <= '0;
      seq_r     <= '0;
      ack_r     <= '0;
      icmp_r    <= '0;
    end else begin
      if (in_take)    in_vld_r <= 1'b1;
      else if (s1_go) in_vld_r <= 1'b0;

      if (s1_go && in_eof_r)        out_vld_r <= 1'b1;
      else if (out_vld_r && !out_stall) out_vld_r <= 1'b0;

      if (s1_go) begin
        if (in_eof_r) begin
          // frame done: start clean
          off_r   <= '0;
          etype_r <= '0;
          ihb_r   <= '0;
          proto_r <= '0;
          dmac_r  <= '0;
          smac_r  <= '0;
          sip_r   <= '0;
          dip_r   <= '0;
          ports_r <= '0;
          seq_r   <= '0;
          ack_r   <= '0;
          icmp_r  <= '0;
        end else begin
          off_r   <= (off_r == OFFSET_MAX) ? off_r : off_r + 7'd1;
          etype_r <= etype_nxt;
          ihb_r   <= ihb_nxt;
          proto_r <= proto_nxt;
          dmac_r  <= dmac_nxt;
          smac_r  <= smac_nxt;
          sip_r   <= sip_nxt;
          dip_r   <= dip_nxt;
          ports_r <= ports_nxt;
          seq_r   <= seq_nxt;
          ack_r   <= ack_nxt;
          icmp_r  <= icmp_nxt;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_data_byte;
      in_eof_r  <= in_end_of_frame;
    end
    if (s1_go && in_eof_r) begin
      st_r      <= st_nxt;
      o_dmac_r  <= dmac_nxt;
      o_smac_r  <= smac_nxt;
      o_sip_r   <= (st_nxt == ST_NOT_IPV4) ? '0 : sip_nxt;
      o_dip_r   <= (st_nxt == ST_NOT_IPV4) ? '0 : dip_nxt;
      o_sport_r <= (st_nxt == ST_TCP || st_nxt == ST_UDP) ? ports_nxt[31:16] : '0;
      o_dport_r <= (st_nxt == ST_TCP || st_nxt == ST_UDP) ? ports_nxt[15:0] : '0;
      o_seq_r   <= (st_nxt == ST_TCP) ? seq_nxt : '0;
      o_ack_r   <= (st_nxt == ST_TCP) ? ack_nxt : '0;
      o_ikind_r <= (st_nxt == ST_ICMP) ? icmp_nxt[15:8] : '0;
      o_icode_r <= (st_nxt == ST_ICMP) ? icmp_nxt[7:0] : '0;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = st_r;
  assign out_dest_mac     = o_dmac_r;
  assign out_source_mac   = o_smac_r;
  assign out_source_ip    = o_sip_r;
  assign out_dest_ip      = o_dip_r;
  assign out_source_port  = o_sport_r;
  assign out_dest_port    = o_dport_r;
  assign out_seq_number   = o_seq_r;
  assign out_ack_number   = o_ack_r;
  assign out_icmp_kind    = o_ikind_r;
  assign out_icmp_subcode = o_icode_r;

`include "ethernet_ipv4_header_parser_core_assert.svh"

  `EIHP_ASSERT_NEXT(a_offset_clears, s1_go && in_eof_r, off_r == '0, "offset not cleared")
  `EIHP_ASSERT_NOW(a_tcp_only_seq, out_vld_r && st_r != ST_TCP, o_seq_r == '0 && o_ack_r == '0, "seq/ack on non-TCP")
  `EIHP_ASSERT_NOW(a_no_ip_on_non_ipv4, out_vld_r && st_r == ST_NOT_IPV4, o_sip_r == '0 && o_dip_r == '0, "IP on non-IPv4")

endmodule
